// File: hw/rtl/wrws_pkg.sv
// Shared constants, payload structs and the sequencer state type for the random walk step block.
package wrws_pkg;

   // The graph size is a power of two, so a node index wraps by truncation.
   localparam int NODES        = 1024;
   localparam int MAX_DEGREE   = 16;
   localparam int NODE_W       = $clog2(NODES);
   localparam int SLOT_W       = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
   localparam int DEG_W        = $clog2(MAX_DEGREE + 1);
   localparam int ADDR_W       = NODE_W + SLOT_W;
   localparam int FIELD_NODE_W = 10;
   localparam int WEIGHT_W     = 16;
   localparam int PROB_W       = 16;
   localparam int CUM_W        = 20;
   localparam int PROD_W       = CUM_W + PROB_W;

   localparam logic [PROB_W-1:0] CP_RESET = 16'd63898;

   localparam logic [1:0] ACT_ADD   = 2'd0;
   localparam logic [1:0] ACT_START = 2'd1;
   localparam logic [1:0] ACT_STEP  = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_NO_EDGES = 2'd2;

   typedef struct packed {
      logic [1:0]              action;
      logic [FIELD_NODE_W-1:0] node_a;
      logic [FIELD_NODE_W-1:0] node_b;
      logic [WEIGHT_W-1:0]     weight;
      logic [PROB_W-1:0]       random;
   } req_type;

   typedef struct packed {
      logic [FIELD_NODE_W-1:0] node;
      logic                    walk_ended;
      logic [1:0]              status;
   } rsp_type;

   typedef struct packed {
      logic [NODE_W-1:0] deg_raddr;
      logic              deg_we;
      logic [NODE_W-1:0] deg_waddr;
      logic [DEG_W-1:0]  deg_wdata;
      logic [ADDR_W-1:0] tab_raddr;
      logic              tab_we;
      logic [ADDR_W-1:0] tab_waddr;
      logic [NODE_W-1:0] nb_wdata;
      logic [CUM_W-1:0]  cum_wdata;
   } store_req_type;

   typedef struct packed {
      logic [DEG_W-1:0]  deg_rdata;
      logic [NODE_W-1:0] nb_rdata;
      logic [CUM_W-1:0]  cum_rdata;
   } store_rsp_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_ADD_DB,
      S_ADD_CHK,
      S_ADD_WA,
      S_ADD_WB,
      S_START_CHK,
      S_STEP_DEG,
      S_STEP_TOT,
      S_STEP_TGT,
      S_PROBE_MUL,
      S_PROBE_CMP,
      S_STEP_NB,
      S_DONE
   } state_type;

endpackage

// File: hw/rtl/wrws_store.sv
// Adjacency slot memories (neighbour and running weight) and the per-node degree memory.
module wrws_store (
   input  logic                   clock,
   input  wrws_pkg::store_req_type req,
   output wrws_pkg::store_rsp_type rsp
);

   logic [wrws_pkg::NODE_W-1:0] nb_mem  [wrws_pkg::NODES * (2 ** wrws_pkg::SLOT_W)];
   logic [wrws_pkg::CUM_W-1:0]  cum_mem [wrws_pkg::NODES * (2 ** wrws_pkg::SLOT_W)];
   logic [wrws_pkg::DEG_W-1:0]  deg_mem [wrws_pkg::NODES];

   logic [wrws_pkg::DEG_W-1:0]  deg_rd_ff;
   logic [wrws_pkg::NODE_W-1:0] nb_rd_ff;
   logic [wrws_pkg::CUM_W-1:0]  cum_rd_ff;

   always_ff @(posedge clock) begin
      if (req.tab_we) begin
         nb_mem[req.tab_waddr]  <= req.nb_wdata;
         cum_mem[req.tab_waddr] <= req.cum_wdata;
      end
      nb_rd_ff  <= nb_mem[req.tab_raddr];
      cum_rd_ff <= cum_mem[req.tab_raddr];
   end

   always_ff @(posedge clock) begin
      if (req.deg_we) begin
         deg_mem[req.deg_waddr] <= req.deg_wdata;
      end
      deg_rd_ff <= deg_mem[req.deg_raddr];
   end

   assign rsp.deg_rdata = deg_rd_ff;
   assign rsp.nb_rdata  = nb_rd_ff;
   assign rsp.cum_rdata = cum_rd_ff;

endmodule

// File: hw/rtl/wrws_mul.sv
// Shared registered multiplier used for the search target and every probe of the search.
module wrws_mul (
   input  logic                        clock,
   input  logic [wrws_pkg::CUM_W-1:0]  op_a,
   input  logic [wrws_pkg::PROB_W-1:0] op_b,
   output logic [wrws_pkg::PROD_W-1:0] prod
);

   logic [wrws_pkg::PROD_W-1:0] prod_ff;
   logic [wrws_pkg::PROD_W-1:0] prod_in;

   assign prod_in = wrws_pkg::PROD_W'(op_a) * wrws_pkg::PROD_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// File: hw/rtl/wrws_seq.sv
// Sequencer: item decode, edge append, degree clear sweep, binary search and result register.
module wrws_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  wrws_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output wrws_pkg::rsp_type           rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [wrws_pkg::PROB_W-1:0] csr_data,
   output wrws_pkg::store_req_type     st_req,
   input  wrws_pkg::store_rsp_type     st_rsp,
   output logic [wrws_pkg::CUM_W-1:0]  mul_a,
   output logic [wrws_pkg::PROB_W-1:0] mul_b,
   input  logic [wrws_pkg::PROD_W-1:0] mul_prod
);

   localparam int NW = wrws_pkg::NODE_W;
   localparam int SW = wrws_pkg::SLOT_W;
   localparam int DW = wrws_pkg::DEG_W;
   localparam int CW = wrws_pkg::CUM_W;

   wrws_pkg::state_type state_ff, state_in;
   logic [NW-1:0]                   clr_ff, clr_in;
   logic [NW-1:0]                   a_ff, a_in;
   logic [NW-1:0]                   b_ff, b_in;
   logic [wrws_pkg::WEIGHT_W-1:0]   weight_ff, weight_in;
   logic [wrws_pkg::PROB_W-1:0]     draw_ff, draw_in;
   logic [DW-1:0]                   da_ff, da_in;
   logic [DW-1:0]                   db_ff, db_in;
   logic [CW-1:0]                   cum_a_ff, cum_a_in;
   logic [SW-1:0]                   lo_ff, lo_in;
   logic [SW-1:0]                   hi_ff, hi_in;
   logic [wrws_pkg::PROD_W-1:0]     target_ff, target_in;
   logic [1:0]                      status_ff, status_in;
   logic                            ended_ff, ended_in;
   logic [NW-1:0]                   cur_ff, cur_in;
   logic                            active_ff, active_in;
   logic [wrws_pkg::PROB_W-1:0]     cp_ff, cp_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   wrws_pkg::rsp_type               rsp_data_ff, rsp_data_in;

   logic [NW-1:0] req_a;
   logic [NW-1:0] req_b;
   logic [SW-1:0] mid;
   logic [SW-1:0] nlo;
   logic [SW-1:0] nhi;
   logic [SW-1:0] nmid;
   logic [CW-1:0] prev;
   logic [CW-1:0] cum_new;
   logic          room;

   assign req_a = req_data.node_a[NW-1:0];
   assign req_b = req_data.node_b[NW-1:0];
   assign mid   = SW'(({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      weight_in    = weight_ff;
      draw_in      = draw_ff;
      da_in        = da_ff;
      db_in        = db_ff;
      cum_a_in     = cum_a_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      target_in    = target_ff;
      status_in    = status_ff;
      ended_in     = ended_ff;
      cur_in       = cur_ff;
      active_in    = active_ff;
      cp_in        = cp_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      nlo          = lo_ff;
      nhi          = hi_ff;
      nmid         = mid;
      prev         = '0;
      cum_new      = '0;
      room         = 1'b0;
      mul_a        = st_rsp.cum_rdata;
      mul_b        = cp_ff;
      st_req           = '0;
      st_req.deg_raddr = req_a;

      if (csr_valid) begin
         cp_in = csr_data;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         wrws_pkg::S_CLEAR: begin
            st_req.deg_we    = 1'b1;
            st_req.deg_waddr = clr_ff;
            st_req.deg_wdata = '0;
            clr_in           = clr_ff + 1'b1;
            if (clr_ff == NW'(wrws_pkg::NODES - 1)) begin
               state_in = wrws_pkg::S_IDLE;
            end
         end
         wrws_pkg::S_IDLE: begin
            if (req_valid) begin
               a_in      = req_a;
               b_in      = req_b;
               weight_in = req_data.weight;
               draw_in   = req_data.random;
               status_in = wrws_pkg::ST_OK;
               ended_in  = 1'b0;
               case (req_data.action)
                  wrws_pkg::ACT_ADD: begin
                     state_in = wrws_pkg::S_ADD_DB;
                  end
                  wrws_pkg::ACT_START: begin
                     cur_in    = req_a;
                     active_in = 1'b1;
                     state_in  = wrws_pkg::S_START_CHK;
                  end
                  wrws_pkg::ACT_STEP: begin
                     st_req.deg_raddr = cur_ff;
                     if (!active_ff) begin
                        ended_in = 1'b1;
                        state_in = wrws_pkg::S_DONE;
                     end else if (req_data.random > cp_ff) begin
                        active_in = 1'b0;
                        ended_in  = 1'b1;
                        state_in  = wrws_pkg::S_DONE;
                     end else begin
                        state_in = wrws_pkg::S_STEP_DEG;
                     end
                  end
                  default: begin
                     state_in = wrws_pkg::S_DONE;
                  end
               endcase
            end
         end
         wrws_pkg::S_ADD_DB: begin
            da_in            = st_rsp.deg_rdata;
            st_req.deg_raddr = b_ff;
            state_in         = wrws_pkg::S_ADD_CHK;
         end
         wrws_pkg::S_ADD_CHK: begin
            db_in = st_rsp.deg_rdata;
            if (a_ff == b_ff) begin
               room = (int'(da_ff) + 2) <= wrws_pkg::MAX_DEGREE;
            end else begin
               room = (int'(da_ff) < wrws_pkg::MAX_DEGREE) &&
                      (int'(st_rsp.deg_rdata) < wrws_pkg::MAX_DEGREE);
            end
            st_req.tab_raddr = {a_ff, SW'(da_ff - 1'b1)};
            if (room) begin
               state_in = wrws_pkg::S_ADD_WA;
            end else begin
               status_in = wrws_pkg::ST_FULL;
               state_in  = wrws_pkg::S_DONE;
            end
         end
         wrws_pkg::S_ADD_WA: begin
            prev             = (da_ff == '0) ? '0 : st_rsp.cum_rdata;
            cum_new          = prev + CW'(weight_ff);
            cum_a_in         = cum_new;
            st_req.tab_we    = 1'b1;
            st_req.tab_waddr = {a_ff, SW'(da_ff)};
            st_req.nb_wdata  = b_ff;
            st_req.cum_wdata = cum_new;
            st_req.deg_we    = 1'b1;
            st_req.deg_waddr = a_ff;
            st_req.deg_wdata = da_ff + 1'b1;
            st_req.tab_raddr = {b_ff, SW'(db_ff - 1'b1)};
            state_in         = wrws_pkg::S_ADD_WB;
         end
         wrws_pkg::S_ADD_WB: begin
            st_req.tab_we    = 1'b1;
            st_req.nb_wdata  = a_ff;
            st_req.deg_we    = 1'b1;
            st_req.deg_waddr = b_ff;
            // A self-loop takes the slot just after the one written in S_ADD_WA.
            if (a_ff == b_ff) begin
               prev             = cum_a_ff;
               st_req.tab_waddr = {b_ff, SW'(da_ff + 1'b1)};
               st_req.deg_wdata = da_ff + DW'(2);
            end else begin
               prev             = (db_ff == '0) ? '0 : st_rsp.cum_rdata;
               st_req.tab_waddr = {b_ff, SW'(db_ff)};
               st_req.deg_wdata = db_ff + 1'b1;
            end
            cum_new          = prev + CW'(weight_ff);
            st_req.cum_wdata = cum_new;
            state_in         = wrws_pkg::S_DONE;
         end
         wrws_pkg::S_START_CHK: begin
            if (st_rsp.deg_rdata == '0) begin
               status_in = wrws_pkg::ST_NO_EDGES;
            end
            state_in = wrws_pkg::S_DONE;
         end
         wrws_pkg::S_STEP_DEG: begin
            lo_in            = '0;
            hi_in            = SW'(st_rsp.deg_rdata - 1'b1);
            st_req.tab_raddr = {cur_ff, SW'(st_rsp.deg_rdata - 1'b1)};
            if (st_rsp.deg_rdata == '0) begin
               status_in = wrws_pkg::ST_NO_EDGES;
               state_in  = wrws_pkg::S_DONE;
            end else begin
               state_in = wrws_pkg::S_STEP_TOT;
            end
         end
         wrws_pkg::S_STEP_TOT: begin
            // The node total arrives now; draw times total is the search target.
            mul_b    = draw_ff;
            state_in = wrws_pkg::S_STEP_TGT;
         end
         wrws_pkg::S_STEP_TGT: begin
            target_in = mul_prod;
            if (lo_ff == hi_ff) begin
               st_req.tab_raddr = {cur_ff, lo_ff};
               state_in         = wrws_pkg::S_STEP_NB;
            end else begin
               st_req.tab_raddr = {cur_ff, mid};
               state_in         = wrws_pkg::S_PROBE_MUL;
            end
         end
         wrws_pkg::S_PROBE_MUL: begin
            state_in = wrws_pkg::S_PROBE_CMP;
         end
         wrws_pkg::S_PROBE_CMP: begin
            if (mul_prod >= target_ff) begin
               nhi = mid;
            end else begin
               nlo = SW'(mid + 1'b1);
            end
            nmid  = SW'(({1'b0, nlo} + {1'b0, nhi}) >> 1);
            lo_in = nlo;
            hi_in = nhi;
            if (nlo == nhi) begin
               st_req.tab_raddr = {cur_ff, nlo};
               state_in         = wrws_pkg::S_STEP_NB;
            end else begin
               st_req.tab_raddr = {cur_ff, nmid};
               state_in         = wrws_pkg::S_PROBE_MUL;
            end
         end
         wrws_pkg::S_STEP_NB: begin
            cur_in   = st_rsp.nb_rdata;
            state_in = wrws_pkg::S_DONE;
         end
         wrws_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.node       = wrws_pkg::FIELD_NODE_W'(cur_ff);
               rsp_data_in.walk_ended = ended_ff;
               rsp_data_in.status     = status_ff;
               state_in               = wrws_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = wrws_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wrws_pkg::S_CLEAR;
         clr_ff       <= '0;
         cur_ff       <= '0;
         active_ff    <= 1'b0;
         cp_ff        <= wrws_pkg::CP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cur_ff       <= cur_in;
         active_ff    <= active_in;
         cp_ff        <= cp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      weight_ff   <= weight_in;
      draw_ff     <= draw_in;
      da_ff       <= da_in;
      db_ff       <= db_in;
      cum_a_ff    <= cum_a_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      target_ff   <= target_in;
      status_ff   <= status_in;
      ended_ff    <= ended_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == wrws_pkg::S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: hw/rtl/weighted_random_walk_step_top.sv
// Top level of the weighted random walk step block.
//
//   Channel  Direction  Handshake               Payload
//   req_     in         req_valid / req_ready   wrws_pkg::req_type
//   rsp_     out        rsp_valid / rsp_ready   wrws_pkg::rsp_type
//   csr_     in         csr_valid / csr_ready   walk continuation probability, 16 bits
//
// After reset the degree memory is swept to zero, one node a cycle, over all 1024 nodes;
// req_ready stays low during the sweep while csr_ transfers are taken as usual.
// An add-edge item reads both degrees, checks for room and writes a slot at each end, or
// ends with ST_FULL after the check. A step that moves reads the degree and the node total,
// forms the target and then makes up to 4 search probes, each a slot read and a multiply,
// through the single read port of the slot memory and the one shared multiplier.
// The result sits in an output register, so a stalled rsp_ side holds the next item only in S_DONE.
module weighted_random_walk_step_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  wrws_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output wrws_pkg::rsp_type           rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [wrws_pkg::PROB_W-1:0] csr_data
);

   wrws_pkg::store_req_type     st_req;
   wrws_pkg::store_rsp_type     st_rsp;
   logic [wrws_pkg::CUM_W-1:0]  mul_a;
   logic [wrws_pkg::PROB_W-1:0] mul_b;
   logic [wrws_pkg::PROD_W-1:0] mul_prod;

   wrws_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .st_req    (st_req),
      .st_rsp    (st_rsp),
      .mul_a     (mul_a),
      .mul_b     (mul_b),
      .mul_prod  (mul_prod)
   );

   wrws_store u_store (
      .clock (clock),
      .req   (st_req),
      .rsp   (st_rsp)
   );

   wrws_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_prod)
   );

endmodule

// File: hw/rtl/wrws_checker.sv
// Port-level checker for the random walk step block, bound to its top level.
module wrws_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input wrws_pkg::rsp_type rsp_data
);

   // The degree sweep always follows reset, so no item can be taken just after it.
   a_busy_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("req_ready high in the cycle after reset");

   // One item at a time: a transfer on req_ leaves the block busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("req_ready still high after an input transfer");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed or dropped");

   // An ended walk never carries an error status, and status code three never appears.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.status == wrws_pkg::ST_OK) ||
                     (!rsp_data.walk_ended &&
                      ((rsp_data.status == wrws_pkg::ST_FULL) ||
                       (rsp_data.status == wrws_pkg::ST_NO_EDGES)))))
      else $error("inconsistent result status");

endmodule

bind weighted_random_walk_step_top wrws_checker u_wrws_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
